[hdl/kvi_pkg.sv]
// Shared types and constants for the keyframe vertex interpolator.
// Holds field widths, operation and register codes and the sequencer state type.
// No dependencies.
package kvi_pkg;

   localparam int MAX_FRAMES_DEF   = 16;
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF   = 16;

   // Fixed field widths of the stream and register interfaces.
   localparam int LOAD_FRAME_W     = 4;
   localparam int LOAD_VERTEX_W    = 6;
   localparam int PHASE_W          = 17;
   localparam int VIDX_W           = 6;
   localparam int FRAME_COUNT_W    = 5;
   localparam int VERTEX_COUNT_W   = 7;
   localparam int CSR_INDEX_W      = 8;
   localparam int CSR_DATA_W       = 8;

   // Q1.16 weight: one equals 1 << WEIGHT_SHIFT.
   localparam int WEIGHT_SHIFT     = 16;
   localparam int WEIGHT_ONE       = 65536;

   // Three position and three normal components per vertex.
   localparam int LANES            = 6;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_INTERP = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_COUNT  = 8'd0,
      REG_VERTEX_COUNT = 8'd1
   } reg_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } seq_state_type;

endpackage

[hdl/keyframe_vertex_interpolator.sv]
// Keyframe vertex interpolator: mesh storage in two memories and a four-stage blend pipeline.
// Depends on kvi_pkg for widths, codes and the sequencer state type.
//
// Usage:
// The req_ stream carries load and interpolate items, selected by req_tuser. A load beat
// writes the position and normal of one vertex in one keyframe and gives no result. An
// interpolate beat picks two frames and a weight from the phase and then reads both
// frames for vertices 0 .. V-1, one vertex per cycle while the output is not stalled,
// through the two read ports of each memory. Each vertex leaves as one rsp_ beat, with
// rsp_tlast on the final vertex. The next request is taken only after the last vertex
// of a run has been issued. With a single frame an interpolate beat gives no result at all.
// The csr_ port sets the frame count (index 0) and the vertex count (index 1); write it
// only while the block is idle. Writes are always taken.
// Reset returns both counts to 1 and empties the pipeline; the memories are not cleared,
// and an entry must be loaded before any interpolation reads it.
// While rsp_tvalid is high and rsp_tready low, the whole pipeline and a running vertex
// sequencer hold their state; a pending request waits until the run has been fully issued.
module keyframe_vertex_interpolator
   import kvi_pkg::*;
#(
   parameter int MAX_FRAMES   = MAX_FRAMES_DEF,
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request stream.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // From bit 0: load_frame, load_vertex, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
   // phase, wrap_mode, zero fill.
   input  logic [((LOAD_FRAME_W + LOAD_VERTEX_W + LANES*COORD_BITS + PHASE_W + 1 + 7)
                  / 8) * 8 - 1:0] req_tdata,
   input  logic                      req_tuser,    // opcode
   // Result stream.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // From bit 0: vertex_index, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
   // out_nrm_z, zero fill.
   output logic [((VIDX_W + LANES*COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                      rsp_tlast,    // last
   // Register writes.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int C       = COORD_BITS;
   localparam int RSP_W   = ((VIDX_W + LANES*C + 7) / 8) * 8;
   localparam int DEPTH   = MAX_FRAMES * MAX_VERTICES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int FR_W    = $clog2(MAX_FRAMES);
   localparam int FC_W    = $clog2(MAX_FRAMES + 1);
   localparam int VX_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VC_W    = $clog2(MAX_VERTICES + 1);
   localparam int TF_W    = PHASE_W + FC_W;
   localparam int PROD_W  = C + PHASE_W + 2;
   localparam int WORD_W  = 3 * C;
   localparam int POS_LSB = LOAD_FRAME_W + LOAD_VERTEX_W;
   localparam int PH_LSB  = POS_LSB + LANES*C;

   // ---------------------------------------------------------------- request fields
   logic [LOAD_FRAME_W-1:0]  req_frame;
   logic [LOAD_VERTEX_W-1:0] req_vertex;
   logic [WORD_W-1:0]        req_pos_word;
   logic [WORD_W-1:0]        req_nrm_word;
   logic [PHASE_W-1:0]       req_phase;
   logic                     req_wrap;

   assign req_frame    = req_tdata[LOAD_FRAME_W-1:0];
   assign req_vertex   = req_tdata[LOAD_FRAME_W +: LOAD_VERTEX_W];
   assign req_pos_word = req_tdata[POS_LSB +: WORD_W];
   assign req_nrm_word = req_tdata[POS_LSB + WORD_W +: WORD_W];
   assign req_phase    = req_tdata[PH_LSB +: PHASE_W];
   assign req_wrap     = req_tdata[PH_LSB + PHASE_W];

   // ---------------------------------------------------------------- configuration
   logic [FRAME_COUNT_W-1:0]  fc_ff;
   logic [VERTEX_COUNT_W-1:0] vc_ff;
   logic [FC_W-1:0]           fc_eff;
   logic [VC_W-1:0]           vc_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= FRAME_COUNT_W'(1);
         vc_ff <= VERTEX_COUNT_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_COUNT:  fc_ff <= csr_data[FRAME_COUNT_W-1:0];
            REG_VERTEX_COUNT: vc_ff <= csr_data[VERTEX_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero acts as one, and counts above the storage saturate.
   always_comb begin
      if (fc_ff == '0) begin
         fc_eff = FC_W'(1);
      end else if (32'(fc_ff) > MAX_FRAMES) begin
         fc_eff = FC_W'(MAX_FRAMES);
      end else begin
         fc_eff = FC_W'(fc_ff);
      end
      if (vc_ff == '0) begin
         vc_eff = VC_W'(1);
      end else if (32'(vc_ff) > MAX_VERTICES) begin
         vc_eff = VC_W'(MAX_VERTICES);
      end else begin
         vc_eff = VC_W'(vc_ff);
      end
   end

   // ---------------------------------------------------------------- handshakes
   seq_state_type state_ff, state_in;
   logic          adv;
   logic          issue;
   logic          req_fire;
   logic          load_fire;
   logic          interp_start;
   logic          iss_last;
   logic          rsp_valid_ff;

   // Every stage moves together whenever the output register can take a new beat.
   assign adv          = !rsp_valid_ff || rsp_tready;
   assign req_fire     = req_tvalid && req_tready;
   assign load_fire    = req_fire && (req_tuser == OP_LOAD);
   assign interp_start = req_fire && (req_tuser == OP_INTERP) && (fc_eff > FC_W'(1));

   // ---------------------------------------------------------------- frame selection
   logic [PHASE_W-1:0] t_sat;
   logic [TF_W-1:0]    tf;
   logic [FC_W:0]      prev_raw;
   logic [FC_W-1:0]    fc_m1;
   logic [FR_W-1:0]    prev_calc;
   logic [FR_W-1:0]    next_calc;
   logic [PHASE_W-1:0] w_calc;

   always_comb begin
      t_sat     = (req_phase > PHASE_W'(WEIGHT_ONE)) ? PHASE_W'(WEIGHT_ONE) : req_phase;
      tf        = TF_W'(t_sat) * TF_W'(fc_eff);
      prev_raw  = (FC_W+1)'(tf >> WEIGHT_SHIFT);
      fc_m1     = fc_eff - FC_W'(1);
      prev_calc = (prev_raw > (FC_W+1)'(fc_m1)) ? FR_W'(fc_m1) : FR_W'(prev_raw);
      if ((FC_W+1)'(prev_calc) + (FC_W+1)'(1) == (FC_W+1)'(fc_eff)) begin
         next_calc = req_wrap ? '0 : prev_calc;
      end else begin
         next_calc = prev_calc + FR_W'(1);
      end
      w_calc    = PHASE_W'(tf - (TF_W'(prev_calc) << WEIGHT_SHIFT));
   end

   logic [FR_W-1:0]    prev_ff;
   logic [FR_W-1:0]    next_ff;
   logic [PHASE_W-1:0] w_ff;
   logic [VX_W-1:0]    vtx_ff, vtx_in;

   always_ff @(posedge clock) begin
      if (interp_start) begin
         prev_ff <= prev_calc;
         next_ff <= next_calc;
         w_ff    <= w_calc;
      end
   end

   // ---------------------------------------------------------------- sequencer
   assign iss_last = (VC_W'(vtx_ff) == vc_eff - VC_W'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (interp_start) state_in = ST_RUN;
         ST_RUN:  if (adv && iss_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_RUN:  issue      = adv;
         default: ;
      endcase
   end

   always_comb begin
      vtx_in = vtx_ff;
      if (interp_start) begin
         vtx_in = '0;
      end else if (issue) begin
         vtx_in = vtx_ff + VX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vtx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         vtx_ff   <= vtx_in;
      end
   end

   // ---------------------------------------------------------------- mesh memories
   logic [WORD_W-1:0] pos_mem [DEPTH];
   logic [WORD_W-1:0] nrm_mem [DEPTH];
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic              wr_in_range;

   assign wr_in_range = (32'(req_frame) < MAX_FRAMES) && (32'(req_vertex) < MAX_VERTICES);
   assign wr_addr     = ADDR_W'(32'(req_frame) * MAX_VERTICES + 32'(req_vertex));
   assign rd_addr_a   = ADDR_W'(32'(prev_ff) * MAX_VERTICES + 32'(vtx_ff));
   assign rd_addr_b   = ADDR_W'(32'(next_ff) * MAX_VERTICES + 32'(vtx_ff));

   always_ff @(posedge clock) begin
      if (load_fire && wr_in_range) begin
         pos_mem[wr_addr] <= req_pos_word;
         nrm_mem[wr_addr] <= req_nrm_word;
      end
   end

   // Stage 1: both frames of one vertex, read through the two read ports.
   logic [2*WORD_W-1:0] s1_a_ff;
   logic [2*WORD_W-1:0] s1_b_ff;
   logic                s1_valid_ff;
   logic [VIDX_W-1:0]   s1_idx_ff;
   logic                s1_last_ff;
   logic [PHASE_W-1:0]  s1_w_ff;

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_a_ff <= {nrm_mem[rd_addr_a], pos_mem[rd_addr_a]};
         s1_b_ff <= {nrm_mem[rd_addr_b], pos_mem[rd_addr_b]};
      end
      if (adv) begin
         s1_idx_ff  <= VIDX_W'(vtx_ff);
         s1_last_ff <= iss_last;
         s1_w_ff    <= w_ff;
      end
   end

   // ---------------------------------------------------------------- blend pipeline
   logic signed [C-1:0]      s2_a_ff    [LANES];
   logic signed [C:0]        s2_diff_ff [LANES];
   logic                     s2_valid_ff;
   logic [VIDX_W-1:0]        s2_idx_ff;
   logic                     s2_last_ff;
   logic signed [PHASE_W:0]  s2_w_ff;

   logic signed [C-1:0]      s3_a_ff    [LANES];
   logic signed [PROD_W-1:0] s3_prod_ff [LANES];
   logic                     s3_valid_ff;
   logic [VIDX_W-1:0]        s3_idx_ff;
   logic                     s3_last_ff;

   logic signed [C-1:0]      rsp_lane_ff [LANES];
   logic [VIDX_W-1:0]        rsp_idx_ff;
   logic                     rsp_last_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         // Stage 2: the difference needs one extra bit.
         for (int k = 0; k < LANES; k++) begin
            s2_a_ff[k]    <= signed'(s1_a_ff[k*C +: C]);
            s2_diff_ff[k] <= (C+1)'(signed'(s1_b_ff[k*C +: C]))
                           - (C+1)'(signed'(s1_a_ff[k*C +: C]));
         end
         s2_idx_ff  <= s1_idx_ff;
         s2_last_ff <= s1_last_ff;
         s2_w_ff    <= signed'({1'b0, s1_w_ff});
         // Stage 3: scale the difference by the weight.
         for (int k = 0; k < LANES; k++) begin
            s3_a_ff[k]    <= s2_a_ff[k];
            s3_prod_ff[k] <= PROD_W'(s2_diff_ff[k]) * PROD_W'(s2_w_ff);
         end
         s3_idx_ff  <= s2_idx_ff;
         s3_last_ff <= s2_last_ff;
         // Output: the arithmetic shift rounds toward minus infinity, and the sum always
         // lies between the two keyframe values, so truncation loses nothing.
         for (int k = 0; k < LANES; k++) begin
            rsp_lane_ff[k] <= s3_a_ff[k] + C'(s3_prod_ff[k] >>> WEIGHT_SHIFT);
         end
         rsp_idx_ff  <= s3_idx_ff;
         rsp_last_ff <= s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------- result port
   logic [LANES*C-1:0] rsp_lanes;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rsp_lanes[k*C +: C] = rsp_lane_ff[k];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_lanes, rsp_idx_ff});
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   a_run_ends_after_last : assert property (@(posedge clock) disable iff (reset)
      (issue && iss_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer kept running after the last vertex was issued");

   a_vertex_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (VC_W'(vtx_ff) < vc_eff))
      else $error("vertex counter ran past the vertex count");

   // A new request may still be taken while stalled, so only the pipeline is checked.
   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(s3_valid_ff) && $stable(rsp_tdata)))
      else $error("pipeline moved while the output was stalled");

   a_weight_bounded : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_w_ff <= PHASE_W'(WEIGHT_ONE)))
      else $error("blend weight above one");

endmodule

[bench/tb_keyframe_vertex_interpolator.sv]
`timescale 1ns / 1ps
// Self-checking bench for keyframe_vertex_interpolator: loads keyframe meshes, runs
// interpolations under random stalls and checks every vertex beat against its own blend math.
// Depends on kvi_pkg and the block's RTL.
module tb_keyframe_vertex_interpolator;
   import kvi_pkg::*;

   localparam int REQ_USED = LOAD_FRAME_W + LOAD_VERTEX_W + LANES*COORD_BITS_DEF + PHASE_W + 1;
   localparam int REQ_W    = ((REQ_USED + 7) / 8) * 8;
   localparam int RSP_USED = VIDX_W + LANES*COORD_BITS_DEF;
   localparam int RSP_W    = ((RSP_USED + 7) / 8) * 8;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 8'd7;
   localparam int SETTLE_CYCLES = MAX_VERTICES_DEF + 16;
   localparam int RANDOM_ITEMS  = 40;
   localparam int PHASE_MAX     = 2**PHASE_W - 1;

   typedef logic signed [COORD_BITS_DEF-1:0] coord_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_MIN,
      FILL_MAX
   } fill_style_type;

   typedef struct packed {
      logic [REQ_W-REQ_USED-1:0]      fill;
      logic                           wrap;
      logic [PHASE_W-1:0]             phase;
      logic [2:0][COORD_BITS_DEF-1:0] nrm;
      logic [2:0][COORD_BITS_DEF-1:0] pos;
      logic [LOAD_VERTEX_W-1:0]       vertex;
      logic [LOAD_FRAME_W-1:0]        frame;
   } req_beat_type;

   typedef struct packed {
      logic [RSP_W-RSP_USED-1:0]      fill;
      logic [2:0][COORD_BITS_DEF-1:0] nrm;
      logic [2:0][COORD_BITS_DEF-1:0] pos;
      logic [VIDX_W-1:0]              vidx;
   } rsp_beat_type;

   typedef struct packed {
      logic         last;
      rsp_beat_type beat;
   } vertex_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;   // see req_beat_type, frame in the lowest bits
   logic                   req_tuser = 1'b0; // opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;        // see rsp_beat_type, vertex index lowest
   logic                   rsp_tlast;        // last
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Mirror of the mesh and the count registers.
   coord_type mesh_pos [MAX_FRAMES_DEF*MAX_VERTICES_DEF][3];
   coord_type mesh_nrm [MAX_FRAMES_DEF*MAX_VERTICES_DEF][3];
   bit        mesh_loaded [MAX_FRAMES_DEF*MAX_VERTICES_DEF];
   logic [FRAME_COUNT_W-1:0]  frame_reg = FRAME_COUNT_W'(1);
   logic [VERTEX_COUNT_W-1:0] vertex_reg = VERTEX_COUNT_W'(1);

   vertex_result_type pending_vertices[$];

   int  mismatch_count = 0;
   int  load_count = 0;
   int  interp_count = 0;
   int  checked_count = 0;
   int  write_count = 0;
   int  stall_left = 0;
   bit  req_steady = 1'b0;
   bit  rsp_steady = 1'b0;
   string axis [3] = '{"x", "y", "z"};

   keyframe_vertex_interpolator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Blend prediction
   // ------------------------------------------------------------------

   function automatic int frames_now();
      int f;
      f = int'(frame_reg);
      if (f == 0) f = 1;
      if (f > MAX_FRAMES_DEF) f = MAX_FRAMES_DEF;
      return f;
   endfunction

   function automatic int vertices_now();
      int v;
      v = int'(vertex_reg);
      if (v == 0) v = 1;
      if (v > MAX_VERTICES_DEF) v = MAX_VERTICES_DEF;
      return v;
   endfunction

   // Phase saturates at 1.0; the earlier frame is clamped so that a phase of 1.0 lands on
   // the last frame with a full weight.
   function automatic void pick_frames(input int phase, input bit wrap, output int prv,
                                       output int nxt, output int weight);
      int f;
      int t;
      int tf;
      f  = frames_now();
      t  = (phase > WEIGHT_ONE) ? WEIGHT_ONE : phase;
      tf = t * f;
      prv = tf >> WEIGHT_SHIFT;
      if (prv > f - 1) prv = f - 1;
      if (wrap) nxt = (prv + 1 == f) ? 0 : prv + 1;
      else      nxt = (prv + 1 > f - 1) ? f - 1 : prv + 1;
      weight = tf - (prv << WEIGHT_SHIFT);
   endfunction

   // The arithmetic shift of the signed product rounds toward minus infinity.
   function automatic coord_type blend_coord(input coord_type a, input coord_type b,
                                             input int weight);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'(weight);
      return coord_type'(longint'(a) + (prod >>> WEIGHT_SHIFT));
   endfunction

   task automatic predict_beat(input logic op, input req_beat_type beat);
      int prv, nxt, weight, idx, ia, ib, nv;
      vertex_result_type r;
      if (op == OP_LOAD) begin
         idx = int'(beat.frame) * MAX_VERTICES_DEF + int'(beat.vertex);
         for (int c = 0; c < 3; c++) begin
            mesh_pos[idx][c] = beat.pos[c];
            mesh_nrm[idx][c] = beat.nrm[c];
         end
         mesh_loaded[idx] = 1'b1;
         load_count++;
      end else begin
         interp_count++;
         if (frames_now() > 1) begin
            pick_frames(int'(beat.phase), beat.wrap, prv, nxt, weight);
            nv = vertices_now();
            for (int j = 0; j < nv; j++) begin
               ia = prv * MAX_VERTICES_DEF + j;
               ib = nxt * MAX_VERTICES_DEF + j;
               r = '0;
               r.beat.vidx = VIDX_W'(j);
               for (int c = 0; c < 3; c++) begin
                  r.beat.pos[c] = blend_coord(mesh_pos[ia][c], mesh_pos[ib][c], weight);
                  r.beat.nrm[c] = blend_coord(mesh_nrm[ia][c], mesh_nrm[ib][c], weight);
               end
               r.last = (j == nv - 1);
               pending_vertices.push_back(r);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure and the checker
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_steady || $urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                                  : int'($urandom_range(0, 2));
      end
   end

   function automatic void flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns mismatch: %s", $time, msg);
   endfunction

   always @(posedge clock) begin : check_results
      vertex_result_type want;
      rsp_beat_type      got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         checked_count++;
         if (pending_vertices.size() == 0) begin
            flag_mismatch($sformatf("vertex beat %0d arrived with nothing pending", got.vidx));
         end else begin
            want = pending_vertices.pop_front();
            if (got.vidx !== want.beat.vidx)
               flag_mismatch($sformatf("vertex_index expected %0d got %0d",
                                       want.beat.vidx, got.vidx));
            for (int c = 0; c < 3; c++) begin
               if (got.pos[c] !== want.beat.pos[c])
                  flag_mismatch($sformatf("vertex %0d out_pos_%s expected %0d got %0d",
                                          want.beat.vidx, axis[c], $signed(want.beat.pos[c]),
                                          $signed(got.pos[c])));
               if (got.nrm[c] !== want.beat.nrm[c])
                  flag_mismatch($sformatf("vertex %0d out_nrm_%s expected %0d got %0d",
                                          want.beat.vidx, axis[c], $signed(want.beat.nrm[c]),
                                          $signed(got.nrm[c])));
            end
            if (rsp_tlast !== want.last)
               flag_mismatch($sformatf("vertex %0d last expected %0b got %0b",
                                       want.beat.vidx, want.last, rsp_tlast));
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   function automatic int idle_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 40));
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return coord_type'(-32768);
         1: return coord_type'(32767);
         2: return coord_type'(0);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      b = '0;
      b.frame  = LOAD_FRAME_W'($urandom);
      b.vertex = LOAD_VERTEX_W'($urandom);
      b.phase  = PHASE_W'($urandom);
      b.wrap   = 1'($urandom);
      for (int c = 0; c < 3; c++) begin
         b.pos[c] = rand_coord();
         b.nrm[c] = rand_coord();
      end
      return b;
   endfunction

   // Valid stays high across back-to-back beats; it drops only for an inserted gap or a settle.
   task automatic send_item(input logic op, input req_beat_type beat);
      int gap;
      gap = req_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_beat(op, beat);
   endtask

   task automatic load_entry(input int frame, input int vertex, input fill_style_type style);
      req_beat_type b;
      b = random_beat();
      b.frame  = LOAD_FRAME_W'(frame);
      b.vertex = LOAD_VERTEX_W'(vertex);
      for (int c = 0; c < 3; c++) begin
         if (style == FILL_MIN) begin
            b.pos[c] = coord_type'(-32768);
            b.nrm[c] = coord_type'(-32768);
         end else if (style == FILL_MAX) begin
            b.pos[c] = coord_type'(32767);
            b.nrm[c] = coord_type'(32767);
         end
      end
      send_item(OP_LOAD, b);
   endtask

   // Loads whatever the coming interpolation would read that was never written.
   task automatic interpolate(input int phase, input bit wrap);
      int prv, nxt, weight, nv;
      req_beat_type b;
      if (frames_now() > 1) begin
         pick_frames(phase, wrap, prv, nxt, weight);
         nv = vertices_now();
         for (int j = 0; j < nv; j++) begin
            if (!mesh_loaded[prv*MAX_VERTICES_DEF + j]) load_entry(prv, j, FILL_RANDOM);
            if (!mesh_loaded[nxt*MAX_VERTICES_DEF + j]) load_entry(nxt, j, FILL_RANDOM);
         end
      end
      b = random_beat();
      b.phase = PHASE_W'(phase);
      b.wrap  = wrap;
      send_item(OP_INTERP, b);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_FRAME_COUNT:  frame_reg = value[FRAME_COUNT_W-1:0];
         REG_VERTEX_COUNT: vertex_reg = value[VERTEX_COUNT_W-1:0];
         default: ;
      endcase
      write_count++;
      @(posedge clock);
   endtask

   function automatic int random_phase();
      int f, k, base;
      f = frames_now();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return WEIGHT_ONE;
         2: return int'($urandom_range(WEIGHT_ONE + 1, PHASE_MAX));
         3, 4: begin
            if (f > 1) begin
               // Straddle the phase where the earlier frame steps up.
               k = int'($urandom_range(1, f - 1));
               base = (k * WEIGHT_ONE + f - 1) / f;
               return base + int'($urandom_range(0, 2)) - 1;
            end
            return int'($urandom_range(0, WEIGHT_ONE));
         end
         default: return int'($urandom_range(0, WEIGHT_ONE));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Counts come out of reset at one frame, so interpolation must stay silent.
   task automatic test_reset_state();
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      load_entry(0, 0, FILL_MAX);
      interpolate(0, 1'b0);
      interpolate(WEIGHT_ONE, 1'b1);
      settle();
   endtask

   task automatic test_extreme_blend();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      write_register(REG_FRAME_COUNT, 8'd2);
      write_register(REG_VERTEX_COUNT, 8'd2);
      for (int j = 0; j < 2; j++) begin
         load_entry(0, j, FILL_MIN);
         load_entry(1, j, FILL_MAX);
      end
      interpolate(0, 1'b0);
      interpolate(1, 1'b0);
      interpolate(WEIGHT_ONE / 2, 1'b1);
      interpolate(WEIGHT_ONE - 1, 1'b0);
      interpolate(WEIGHT_ONE, 1'b0);
      interpolate(WEIGHT_ONE, 1'b1);
      interpolate(PHASE_MAX, 1'b1);
      interpolate(PHASE_MAX, 1'b0);
      // Falling values make the product negative, where floor rounding shows.
      load_entry(0, 0, FILL_MAX);
      load_entry(1, 0, FILL_MIN);
      interpolate(1, 1'b0);
      interpolate(WEIGHT_ONE / 2 - 1, 1'b0);
      interpolate(WEIGHT_ONE - 1, 1'b1);
      settle();
   endtask

   task automatic test_frame_boundaries();
      int marks [6] = '{21845, 21846, 43690, 43691, 65535, 65536};
      rsp_steady = 1'b1;
      write_register(REG_FRAME_COUNT, 8'd3);
      write_register(REG_VERTEX_COUNT, 8'd1);
      for (int m = 0; m < 2; m++) begin
         for (int i = 0; i < 6; i++) interpolate(marks[i], m[0]);
      end
      settle();
   endtask

   // The full-size runs stay on the last frame so that one frame of loads covers them.
   task automatic test_register_limits();
      rsp_steady = 1'b0;
      write_register(REG_FRAME_COUNT, 8'd0);
      write_register(REG_VERTEX_COUNT, 8'd0);
      interpolate(30000, 1'b1);
      settle();
      write_register(REG_FRAME_COUNT, 8'hFF);
      write_register(REG_VERTEX_COUNT, 8'hFF);
      write_register(REG_UNMAPPED, 8'h03);
      interpolate(WEIGHT_ONE, 1'b0);
      interpolate(62000, 1'b0);
      settle();
      write_register(REG_FRAME_COUNT, 8'd16);
      write_register(REG_VERTEX_COUNT, 8'd64);
      interpolate(WEIGHT_ONE - 1, 1'b0);
      settle();
   endtask

   task automatic test_random_traffic();
      int issued;
      int n;
      int r;
      bit paused;
      issued = 0;
      paused = 1'b0;
      while (issued < RANDOM_ITEMS) begin
         r = int'($urandom_range(0, 9));
         if (r == 0)      write_register(REG_FRAME_COUNT, CSR_DATA_W'($urandom_range(0, 255)));
         else if (r == 1) write_register(REG_FRAME_COUNT, 8'd16);
         else if (r == 2) write_register(REG_FRAME_COUNT, 8'd1);
         else             write_register(REG_FRAME_COUNT, CSR_DATA_W'($urandom_range(2, 6)));
         r = int'($urandom_range(0, 19));
         if (r == 0)      write_register(REG_VERTEX_COUNT, 8'd64);
         else if (r == 1) write_register(REG_VERTEX_COUNT, CSR_DATA_W'($urandom_range(0, 255)));
         else             write_register(REG_VERTEX_COUNT, CSR_DATA_W'($urandom_range(1, 8)));
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         n = int'($urandom_range(8, 20));
         for (int i = 0; i < n; i++) begin
            // Once in the run the sender holds off until the pipeline has drained.
            if (!paused && issued >= RANDOM_ITEMS / 2) begin
               settle();
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 3)
               load_entry(int'($urandom_range(0, MAX_FRAMES_DEF - 1)),
                          int'($urandom_range(0, MAX_VERTICES_DEF - 1)), FILL_RANDOM);
            else
               interpolate(random_phase(), 1'($urandom_range(0, 1)));
            issued++;
         end
         settle();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_extreme_blend();
      test_frame_boundaries();
      test_register_limits();
      test_random_traffic();
      settle();
      $display("Covered %0d loads and %0d interpolations over %0d register writes,",
               load_count, interp_count, write_count);
      $display("with %0d vertex beats compared under random gaps and stalls.", checked_count);
      if (mismatch_count == 0) begin
         $display("tb_keyframe_vertex_interpolator: clean");
      end else begin
         $display("tb_keyframe_vertex_interpolator: errors");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Run timed out with %0d vertex beats still pending.", pending_vertices.size());
      $display("tb_keyframe_vertex_interpolator: errors");
      $finish;
   end

endmodule
